// ===== hdl/rfc_pkg.sv =====
package rfc_pkg;

   // Frame layout constants.
   localparam logic [7:0] HDR_BYTE    = 8'hFF;
   localparam logic [8:0] MIN_FRAME   = 9'd5;
   localparam logic [9:0] FRAME_EXTRA = 10'd3;
   localparam logic [9:0] PAYLOAD_END = 10'd2;
   localparam logic [8:0] CMD_POS     = 9'd3;
   localparam logic [8:0] LEN_POS     = 9'd2;
   localparam logic [8:0] HDR2_POS    = 9'd1;
   localparam logic [8:0] CNT_MAX     = 9'd511;

   // Largest number of data bytes that a frame may carry.
   localparam int unsigned MAX_DATA  = 64;
   localparam logic [7:0]  LEN_LIMIT = 8'(MAX_DATA + 1);

   // Verdict codes.
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_HEADER   = 3'd1;
   localparam logic [2:0] ERR_SHORT    = 3'd2;
   localparam logic [2:0] ERR_LENGTH   = 3'd3;
   localparam logic [2:0] ERR_CHECKSUM = 3'd4;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic       is_payload;
      logic       verdict_valid;
      logic       frame_good;
      logic [2:0] error_kind;
      logic [7:0] command_code;
   } result_type;

endpackage

// ===== hdl/rfc_req_if.sv =====
interface rfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== hdl/rfc_rsp_if.sv =====
interface rfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] echo_byte;
   logic       is_payload;
   logic       verdict_valid;
   logic       frame_good;
   logic [2:0] error_kind;
   logic [7:0] command_code;

   modport source (output valid, output echo_byte, output is_payload, output verdict_valid,
                   output frame_good, output error_kind, output command_code, input ready);
   modport sink   (input valid, input echo_byte, input is_payload, input verdict_valid,
                   input frame_good, input error_kind, input command_code, output ready);
endinterface

// ===== hdl/rfc_check_core.sv =====
// Frame state and per-byte checks. The result is combinational from the
// current byte and the stored frame state; the state advances on accept.
module rfc_check_core #(
   parameter int unsigned MAX_DATA = rfc_pkg::MAX_DATA
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  logic                  frame_end,
   output rfc_pkg::result_type   result
);

   // Largest declared length that can still pass the length check.
   localparam logic [7:0] LEN_LIMIT = 8'(MAX_DATA + 1);

   logic [8:0] byte_count_ff, byte_count_in, step_count;
   logic       header_bad_ff, header_bad_in, step_header_bad;
   logic [7:0] length_field_ff, length_field_in, step_length;
   logic [7:0] running_sum_ff, running_sum_in, step_sum;
   logic [7:0] previous_byte_ff, previous_byte_in;
   logic [7:0] held_command_ff, held_command_in, step_command;
   logic       payload;
   logic [2:0] kind;

   always_comb begin
      step_header_bad = header_bad_ff;
      step_length     = length_field_ff;
      step_sum        = running_sum_ff;
      step_command    = held_command_ff;
      payload         = 1'b0;

      if (byte_count_ff == rfc_pkg::HDR2_POS) begin
         if (previous_byte_ff != rfc_pkg::HDR_BYTE || rx_byte != rfc_pkg::HDR_BYTE) begin
            step_header_bad = 1'b1;
         end
      end else if (byte_count_ff == rfc_pkg::LEN_POS) begin
         step_length = rx_byte;
         step_sum    = rx_byte;
      end else if (byte_count_ff >= rfc_pkg::CMD_POS) begin
         if (byte_count_ff == rfc_pkg::CMD_POS) begin
            step_command = rx_byte;
         end
         if ({1'b0, byte_count_ff} < {2'b00, length_field_ff} + rfc_pkg::PAYLOAD_END) begin
            payload  = 1'b1;
            step_sum = running_sum_ff + rx_byte;
         end
      end

      step_count = (byte_count_ff == rfc_pkg::CNT_MAX) ? byte_count_ff
                                                       : byte_count_ff + 9'd1;

      // First failing check wins.
      if (step_count < 9'd2 || step_header_bad) begin
         kind = rfc_pkg::ERR_HEADER;
      end else if (step_count < rfc_pkg::MIN_FRAME) begin
         kind = rfc_pkg::ERR_SHORT;
      end else if ({1'b0, step_count} != {2'b00, step_length} + rfc_pkg::FRAME_EXTRA ||
                   step_length > LEN_LIMIT) begin
         kind = rfc_pkg::ERR_LENGTH;
      end else if (rx_byte != ~step_sum) begin
         kind = rfc_pkg::ERR_CHECKSUM;
      end else begin
         kind = rfc_pkg::ERR_NONE;
      end

      result.echo_byte     = rx_byte;
      result.is_payload    = payload;
      result.verdict_valid = frame_end;
      result.frame_good    = frame_end && (kind == rfc_pkg::ERR_NONE);
      result.error_kind    = frame_end ? kind : rfc_pkg::ERR_NONE;
      result.command_code  = frame_end ? step_command : 8'd0;

      // The last byte of a frame returns everything to the idle state.
      if (frame_end) begin
         byte_count_in    = '0;
         header_bad_in    = 1'b0;
         length_field_in  = '0;
         running_sum_in   = '0;
         previous_byte_in = '0;
         held_command_in  = '0;
      end else begin
         byte_count_in    = step_count;
         header_bad_in    = step_header_bad;
         length_field_in  = step_length;
         running_sum_in   = step_sum;
         previous_byte_in = rx_byte;
         held_command_in  = step_command;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         header_bad_ff    <= 1'b0;
         length_field_ff  <= '0;
         running_sum_ff   <= '0;
         previous_byte_ff <= '0;
         held_command_ff  <= '0;
      end else if (accept) begin
         byte_count_ff    <= byte_count_in;
         header_bad_ff    <= header_bad_in;
         length_field_ff  <= length_field_in;
         running_sum_ff   <= running_sum_in;
         previous_byte_ff <= previous_byte_in;
         held_command_ff  <= held_command_in;
      end
   end

endmodule

// ===== hdl/rx_frame_checker.sv =====
// Channel    Direction  Handshake      Carries
// req_if     in         valid/ready    rx_byte, frame_end (one received byte)
// rsp_if     out        valid/ready    echo_byte, is_payload, verdict_valid,
//                                      frame_good, error_kind, command_code
//
// Each request is checked against the frame state and its result is written
// into the output register on the accepting edge.
// A new request is taken every cycle while the output register is empty or
// being emptied, so the sustained rate is one byte per cycle.
// Reset is synchronous and clears the frame state and the output valid flag.
// A stall on rsp_if holds the result and stops further requests until it goes.
module rx_frame_checker #(
   parameter int unsigned MAX_DATA = rfc_pkg::MAX_DATA
) (
   input  logic       clock,
   input  logic       reset,
   rfc_req_if.sink    req_if,
   rfc_rsp_if.source  rsp_if
);

   logic                 req_accept;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rfc_pkg::result_type  result;
   rfc_pkg::result_type  rsp_data_ff;

   // The output register is free when it is empty or its contents are being
   // taken in this cycle, so a fresh request may follow without a gap.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   // The checking logic keeps the frame state: position in the frame, the
   // header flag, the length byte, the running checksum and the command.
   rfc_check_core #(
      .MAX_DATA (MAX_DATA)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_if.rx_byte),
      .frame_end (req_if.frame_end),
      .result    (result)
   );

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload needs no reset; it is only looked at while valid is high.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.echo_byte     = rsp_data_ff.echo_byte;
   assign rsp_if.is_payload    = rsp_data_ff.is_payload;
   assign rsp_if.verdict_valid = rsp_data_ff.verdict_valid;
   assign rsp_if.frame_good    = rsp_data_ff.frame_good;
   assign rsp_if.error_kind    = rsp_data_ff.error_kind;
   assign rsp_if.command_code  = rsp_data_ff.command_code;

endmodule

// ===== hdl/rfc_checker.sv =====
module rfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_echo_byte,
   input logic       rsp_verdict_valid,
   input logic       rsp_frame_good,
   input logic [2:0] rsp_error_kind,
   input logic [7:0] rsp_command_code
);

   // A waiting result is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // With nothing waiting at the output a request is always taken.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output register");

   // Every accepted request shows its byte at the output in the next cycle.
   a_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_echo_byte == $past(req_rx_byte))
      else $error("echoed byte missing or wrong");

   // A good frame carries a verdict and no error code.
   a_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_good |->
         rsp_verdict_valid && rsp_error_kind == rfc_pkg::ERR_NONE)
      else $error("good frame with inconsistent verdict");

   // Verdict fields are quiet on bytes other than the last.
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_verdict_valid |->
         !rsp_frame_good && rsp_error_kind == rfc_pkg::ERR_NONE && rsp_command_code == 8'd0)
      else $error("verdict fields set on a non-final byte");

endmodule

bind rx_frame_checker rfc_checker u_rfc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .req_rx_byte       (req_if.rx_byte),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_echo_byte     (rsp_if.echo_byte),
   .rsp_verdict_valid (rsp_if.verdict_valid),
   .rsp_frame_good    (rsp_if.frame_good),
   .rsp_error_kind    (rsp_if.error_kind),
   .rsp_command_code  (rsp_if.command_code)
);
